@@ design/ordered_list_with_position_delete_assert.svh @@
// Assertion macros used by the list engine (olpd_back)
`ifndef ORDERED_LIST_WITH_POSITION_DELETE_ASSERT_SVH
`define ORDERED_LIST_WITH_POSITION_DELETE_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define OLPD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset
`define OLPD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ design/olpd_pkg.sv @@
// Shared types and constants for the ordered list with position delete
`default_nettype none
package olpd_pkg;

  localparam int CAPACITY    = 16;
  localparam int MAX_RESULTS = 16;
  localparam int CNT_W       = $clog2(CAPACITY + 1);
  localparam int IDX_W       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int LEN_W       = 5;
  localparam int VAL_W       = 32;
  localparam int POS_W       = 8;
  localparam int OPC_W       = 3;
  localparam int Q_DEPTH     = 2;

  // Input opcodes
  localparam logic [OPC_W-1:0] OP_APPEND   = 3'd0;
  localparam logic [OPC_W-1:0] OP_DEL_HEAD = 3'd1;
  localparam logic [OPC_W-1:0] OP_DEL_TAIL = 3'd2;
  localparam logic [OPC_W-1:0] OP_DEL_POS  = 3'd3;
  localparam logic [OPC_W-1:0] OP_DUMP_FWD = 3'd4;
  localparam logic [OPC_W-1:0] OP_DUMP_REV = 3'd5;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_BADPOS = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    CMD_NOP,
    CMD_APPEND,
    CMD_DELETE,
    CMD_DUMP_FWD,
    CMD_DUMP_REV
  } cmd_kind_t;

  typedef enum logic [1:0] {
    DEL_HEAD,
    DEL_TAIL,
    DEL_POS
  } del_sel_t;

  typedef struct packed {
    cmd_kind_t         kind;
    del_sel_t          del_sel;
    logic signed [VAL_W-1:0] value;
    logic [POS_W-1:0]  position;
  } cmd_t;

  typedef enum logic {
    BK_RUN,
    BK_DUMP
  } back_state_t;

endpackage
`default_nettype wire

@@ design/olpd_front.sv @@
// Front end: accepts input transfers and decodes them into list commands
`default_nettype none
module olpd_front
  import olpd_pkg::*;
(
  input  wire logic                    s_tvalid,
  output logic                         s_tready,
  input  wire logic [OPC_W-1:0]        opcode,
  input  wire logic signed [VAL_W-1:0] value,
  input  wire logic [POS_W-1:0]        position,
  output logic                         q_push,
  input  wire logic                    q_full,
  output cmd_t                         q_cmd
);

  // Take a transfer whenever the queue has room
  assign s_tready = !q_full;
  assign q_push   = s_tvalid && !q_full;

  // Decode the opcode into a command
  always_comb begin
    q_cmd          = '0;
    q_cmd.kind     = CMD_NOP;
    q_cmd.del_sel  = DEL_HEAD;
    q_cmd.value    = value;
    q_cmd.position = position;
    case (opcode)
      OP_APPEND:   q_cmd.kind = CMD_APPEND;
      OP_DEL_HEAD: begin
        q_cmd.kind    = CMD_DELETE;
        q_cmd.del_sel = DEL_HEAD;
      end
      OP_DEL_TAIL: begin
        q_cmd.kind    = CMD_DELETE;
        q_cmd.del_sel = DEL_TAIL;
      end
      OP_DEL_POS: begin
        q_cmd.kind    = CMD_DELETE;
        q_cmd.del_sel = DEL_POS;
      end
      OP_DUMP_FWD: q_cmd.kind = CMD_DUMP_FWD;
      OP_DUMP_REV: q_cmd.kind = CMD_DUMP_REV;
      default:     q_cmd.kind = CMD_NOP;
    endcase
  end

endmodule
`default_nettype wire

@@ design/olpd_queue.sv @@
// Short command queue between the front end and the list engine
`default_nettype none
module olpd_queue
  import olpd_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire cmd_t push_cmd,
  output logic      full,
  input  wire logic pop,
  output logic      not_empty,
  output cmd_t      head_cmd
);

  localparam int PTR_W  = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int FILL_W = $clog2(Q_DEPTH + 1);

  cmd_t              slots [Q_DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [FILL_W-1:0] fill;

  assign full      = (fill == FILL_W'(Q_DEPTH));
  assign not_empty = (fill != '0);
  assign head_cmd  = slots[rd_ptr];

  // Advance pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  // Store the pushed command
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

endmodule
`default_nettype wire

@@ design/olpd_back.sv @@
// List engine: holds the compacted entries and produces results
`default_nettype none
`include "ordered_list_with_position_delete_assert.svh"
module olpd_back
  import olpd_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                q_valid,
  input  wire cmd_t                q_cmd,
  output logic                     q_pop,
  output logic                     m_tvalid,
  input  wire logic                m_tready,
  output status_t                  out_status,
  output logic signed [VAL_W-1:0]  out_value,
  output logic [LEN_W-1:0]         out_length,
  output logic                     out_last
);

  logic signed [VAL_W-1:0] cells [CAPACITY];
  logic [CNT_W-1:0]        count;
  logic [CNT_W-1:0]        count_next;
  logic [IDX_W-1:0]        dump_k;
  logic [IDX_W-1:0]        dump_k_next;
  logic                    dump_rev;
  logic                    dump_rev_next;
  back_state_t             state;
  back_state_t             state_next;

  logic                    out_free;
  logic                    load;
  status_t                 ld_status;
  logic signed [VAL_W-1:0] ld_value;
  logic [CNT_W-1:0]        ld_count;
  logic                    ld_last;
  logic                    do_append;
  logic                    do_delete;
  logic [IDX_W-1:0]        del_idx;
  logic [IDX_W-1:0]        rd_idx;
  logic signed [VAL_W-1:0] rd_val;
  logic [CNT_W-1:0]        dump_n;
  logic                    pos_bad;

  assign out_free = !m_tvalid || m_tready;
  assign dump_n   = (count > CNT_W'(MAX_RESULTS)) ? CNT_W'(MAX_RESULTS) : count;
  assign pos_bad  = (q_cmd.position == '0) || (32'(q_cmd.position) > 32'(count));

  // Pick the delete index from the command
  always_comb begin
    case (q_cmd.del_sel)
      DEL_HEAD: del_idx = '0;
      DEL_TAIL: del_idx = IDX_W'(count - 1'b1);
      DEL_POS:  del_idx = IDX_W'(q_cmd.position - 1'b1);
      default:  del_idx = '0;
    endcase
  end

  // Single read port: dump index while dumping, delete index otherwise
  always_comb begin
    if (state == BK_DUMP) begin
      rd_idx = dump_rev ? IDX_W'(count - 1'b1 - CNT_W'(dump_k)) : dump_k;
    end else begin
      rd_idx = del_idx;
    end
  end
  assign rd_val = cells[rd_idx];

  // Sequence commands and build the next result
  always_comb begin
    state_next    = state;
    count_next    = count;
    dump_k_next   = dump_k;
    dump_rev_next = dump_rev;
    q_pop         = 1'b0;
    load          = 1'b0;
    ld_status     = ST_OK;
    ld_value      = '0;
    ld_count      = count;
    ld_last       = 1'b1;
    do_append     = 1'b0;
    do_delete     = 1'b0;
    case (state)
      BK_RUN: begin
        if (q_valid && out_free) begin
          q_pop = 1'b1;
          case (q_cmd.kind)
            CMD_APPEND: begin
              load = 1'b1;
              if (count >= CNT_W'(CAPACITY)) begin
                ld_status = ST_FULL;
              end else begin
                do_append  = 1'b1;
                count_next = count + 1'b1;
                ld_count   = count + 1'b1;
              end
            end
            CMD_DELETE: begin
              load = 1'b1;
              if (count == '0) begin
                ld_status = ST_EMPTY;
              end else if ((q_cmd.del_sel == DEL_POS) && pos_bad) begin
                ld_status = ST_BADPOS;
              end else begin
                do_delete  = 1'b1;
                ld_value   = rd_val;
                count_next = count - 1'b1;
                ld_count   = count - 1'b1;
              end
            end
            CMD_DUMP_FWD, CMD_DUMP_REV: begin
              if (count == '0) begin
                load      = 1'b1;
                ld_status = ST_EMPTY;
              end else begin
                state_next    = BK_DUMP;
                dump_k_next   = '0;
                dump_rev_next = (q_cmd.kind == CMD_DUMP_REV);
              end
            end
            default: load = 1'b1;
          endcase
        end
      end
      BK_DUMP: begin
        if (out_free) begin
          load     = 1'b1;
          ld_value = rd_val;
          ld_last  = (CNT_W'(dump_k) == dump_n - 1'b1);
          if (ld_last) begin
            state_next = BK_RUN;
          end else begin
            dump_k_next = dump_k + 1'b1;
          end
        end
      end
      default: state_next = BK_RUN;
    endcase
  end

  // Hold control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= BK_RUN;
      count    <= '0;
      dump_k   <= '0;
      dump_rev <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      state    <= state_next;
      count    <= count_next;
      dump_k   <= dump_k_next;
      dump_rev <= dump_rev_next;
      if (load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Load the output register
  always_ff @(posedge clk) begin
    if (load) begin
      out_status <= ld_status;
      out_value  <= ld_value;
      out_length <= LEN_W'(ld_count);
      out_last   <= ld_last;
    end
  end

  // Write at the tail, or close the gap left by a delete
  always_ff @(posedge clk) begin
    for (int i = 0; i < CAPACITY; i++) begin
      if (do_append && (CNT_W'(i) == count)) begin
        cells[i] <= q_cmd.value;
      end else if (do_delete && (i < CAPACITY - 1) && (IDX_W'(i) >= del_idx)) begin
        cells[i] <= cells[(i < CAPACITY - 1) ? i + 1 : i];
      end
    end
  end

  `OLPD_ASSERT_NOW(a_count_bound, 1'b1, count <= CNT_W'(CAPACITY), "count above capacity")
  `OLPD_ASSERT_NOW(a_dump_in_range, state == BK_DUMP, CNT_W'(dump_k) < count, "dump index out of range")
  `OLPD_ASSERT_NEXT(a_dump_keeps_count, state == BK_DUMP, $stable(count), "count moved during dump")
  `OLPD_ASSERT_NOW(a_mid_run_in_dump, m_tvalid && !out_last, state == BK_DUMP, "open run outside dump")

endmodule
`default_nettype wire

@@ design/ordered_list_with_position_delete.sv @@
// Top level of the ordered list with head, tail and position delete
//
//   channel | dir | tdata (low bit up)               | tuser       | tlast
//   s_*     | in  | value[31:0], position[39:32]     | opcode[2:0] | -
//   m_*     | out | item_value[31:0], length[36:32] | status[1:0] | last
//
// Appends, deletes and unused opcodes give one result each; the engine takes
// one command a cycle while the output register drains and no dump is running.
// A dump of n entries enters the dump state, then gives one result per entry,
// one entry at a time (single read port on the entry cells).
// Reset is synchronous; the list comes up empty with no clearing pass.
// A stall on m_tready holds the result; the two-slot queue takes up to two more.
`default_nettype none
module ordered_list_with_position_delete
  import olpd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [39:0] s_tdata,   // value[31:0], position[39:32]
  input  wire logic [2:0]  s_tuser,   // opcode[2:0]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [39:0]      m_tdata,   // item_value[31:0], length[36:32], zero pad
  output logic [1:0]       m_tuser,   // status[1:0]
  output logic             m_tlast
);

  logic                    q_push;
  logic                    q_full;
  logic                    q_pop;
  logic                    q_valid;
  cmd_t                    in_cmd;
  cmd_t                    head_cmd;
  status_t                 out_status;
  logic signed [VAL_W-1:0] out_value;
  logic [LEN_W-1:0]        out_length;

  olpd_front u_front (
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .opcode   (s_tuser),
    .value    (s_tdata[31:0]),
    .position (s_tdata[39:32]),
    .q_push   (q_push),
    .q_full   (q_full),
    .q_cmd    (in_cmd)
  );

  olpd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_cmd  (in_cmd),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .head_cmd  (head_cmd)
  );

  olpd_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_valid),
    .q_cmd      (head_cmd),
    .q_pop      (q_pop),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .out_status (out_status),
    .out_value  (out_value),
    .out_length (out_length),
    .out_last   (m_tlast)
  );

  // Pack the result fields
  assign m_tdata = {3'b000, out_length, out_value};
  assign m_tuser = out_status;

endmodule
`default_nettype wire

@@ sim/olpd_checker.sv @@
`timescale 1ns / 1ps
// Checker that mirrors the ordered list and compares every result transfer
module olpd_checker
  import olpd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [39:0] s_tdata,   // value[31:0], position[39:32]
  input  logic [2:0]  s_tuser,   // opcode[2:0]
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [39:0] m_tdata,   // item_value[31:0], length[36:32], zero pad
  input  logic [1:0]  m_tuser,   // status[1:0]
  input  logic        m_tlast,
  output int          mismatches,
  output int          outstanding
);

  typedef struct {
    status_t                 status;
    logic signed [VAL_W-1:0] item_value;
    logic [LEN_W-1:0]        length;
    logic                    last;
  } list_result_t;

  // Mirror of the list contents, head at index zero
  logic signed [VAL_W-1:0] cells [CAPACITY];
  int unsigned             held;
  list_result_t            awaited [$];

  function automatic void post(status_t st, logic signed [VAL_W-1:0] v, logic fin);
    list_result_t r;
    r.status     = st;
    r.item_value = v;
    r.length     = held[LEN_W-1:0];
    r.last       = fin;
    awaited.push_back(r);
  endfunction

  // Apply one command to the mirror and queue the results it causes
  function automatic void apply_list_op(logic [OPC_W-1:0] opc,
                                        logic signed [VAL_W-1:0] val,
                                        logic [POS_W-1:0] pos);
    int unsigned             idx;
    int unsigned             n;
    logic signed [VAL_W-1:0] taken;
    case (opc)
      OP_APPEND: begin
        if (held >= CAPACITY) begin
          post(ST_FULL, '0, 1'b1);
        end else begin
          cells[held] = val;
          held++;
          post(ST_OK, '0, 1'b1);
        end
      end
      OP_DEL_HEAD, OP_DEL_TAIL, OP_DEL_POS: begin
        // empty list is reported before any position check
        if (held == 0) begin
          post(ST_EMPTY, '0, 1'b1);
        end else if (opc == OP_DEL_POS && (pos == 0 || pos > held)) begin
          post(ST_BADPOS, '0, 1'b1);
        end else begin
          if (opc == OP_DEL_HEAD) idx = 0;
          else if (opc == OP_DEL_TAIL) idx = held - 1;
          else idx = int'(pos) - 1;
          taken = cells[idx];
          for (int unsigned i = idx; i + 1 < held; i++) cells[i] = cells[i + 1];
          held--;
          post(ST_OK, taken, 1'b1);
        end
      end
      OP_DUMP_FWD, OP_DUMP_REV: begin
        if (held == 0) begin
          post(ST_EMPTY, '0, 1'b1);
        end else begin
          n = (held > MAX_RESULTS) ? MAX_RESULTS : held;
          for (int unsigned k = 0; k < n; k++)
            post(ST_OK, cells[(opc == OP_DUMP_FWD) ? k : held - 1 - k], k + 1 == n);
        end
      end
      default: post(ST_OK, '0, 1'b1);
    endcase
  endfunction

  function automatic void check_field(string name, longint want, longint got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      mismatches++;
    end
  endfunction

  // Sample on the falling edge: values are settled and equal those at the next rise
  always @(negedge clk) begin
    list_result_t want;
    if (rst) begin
      held        = 0;
      mismatches  = 0;
      awaited.delete();
    end else begin
      if (s_tvalid && s_tready)
        apply_list_op(s_tuser, s_tdata[VAL_W-1:0], s_tdata[VAL_W+POS_W-1:VAL_W]);
      if (m_tvalid && m_tready) begin
        if (awaited.size() == 0) begin
          $error("result transfer with none expected: status %0d item_value %0d length %0d",
                 m_tuser, $signed(m_tdata[VAL_W-1:0]), m_tdata[VAL_W+LEN_W-1:VAL_W]);
          mismatches++;
        end else begin
          want = awaited.pop_front();
          check_field("status", want.status, m_tuser);
          check_field("item_value", want.item_value, $signed(m_tdata[VAL_W-1:0]));
          check_field("length", want.length, m_tdata[VAL_W+LEN_W-1:VAL_W]);
          check_field("last", want.last, m_tlast);
          check_field("pad", 0, m_tdata[39:VAL_W+LEN_W]);
        end
      end
    end
    outstanding = awaited.size();
  end

endmodule

@@ sim/tb.sv @@
`timescale 1ns / 1ps
// Stimulus and verdict for the ordered list with position delete
module tb;
  import olpd_pkg::*;

  localparam logic [OPC_W-1:0] OP_SPARE_LO = 3'd6;
  localparam logic [OPC_W-1:0] OP_SPARE_HI = 3'd7;
  localparam int ITEMS_PER_PHASE = 125;

  typedef enum {TREND_FILL, TREND_DRAIN, TREND_MIX} trend_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata = '0;
  logic [2:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;
  logic [1:0]  m_tuser;
  logic        m_tlast;
  int          mismatches;
  int          outstanding;
  int          gap_pct = 0;
  int          stall_pct = 0;
  int          gap_by_phase[4]   = '{0, 62, 0, 38};
  int          stall_by_phase[4] = '{0, 0, 62, 38};

  ordered_list_with_position_delete uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast)
  );

  olpd_checker chk (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast), .mismatches(mismatches), .outstanding(outstanding)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Stall the result side at the rate of the current phase
  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= stall_pct);
  end

  // Present one command, with random idle cycles ahead of it, and hold until transferred
  task automatic send_item(input logic [OPC_W-1:0] opc, input logic signed [VAL_W-1:0] val,
                           input logic [POS_W-1:0] pos);
    logic ready_seen;
    while ($urandom_range(99) < gap_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= opc;
    s_tdata  <= {pos, val};
    do begin
      @(negedge clk);
      ready_seen = s_tready;
      @(posedge clk);
    end while (!ready_seen);
  endtask

  function automatic logic [OPC_W-1:0] any_delete();
    case ($urandom_range(2))
      0:       return OP_DEL_HEAD;
      1:       return OP_DEL_TAIL;
      default: return OP_DEL_POS;
    endcase
  endfunction

  function automatic logic [OPC_W-1:0] any_dump();
    return $urandom_range(1) ? OP_DUMP_REV : OP_DUMP_FWD;
  endfunction

  function automatic logic [OPC_W-1:0] any_spare();
    return $urandom_range(1) ? OP_SPARE_HI : OP_SPARE_LO;
  endfunction

  initial begin
    trend_t           trend;
    int               roll;
    logic [OPC_W-1:0] opc;
    logic [POS_W-1:0] pos;

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Empty list: every delete and both dumps
    send_item(OP_DUMP_FWD, 0, 0);
    send_item(OP_DUMP_REV, 0, 0);
    send_item(OP_DEL_HEAD, 0, 0);
    send_item(OP_DEL_TAIL, 0, 0);
    send_item(OP_DEL_POS, 0, 1);
    // Extreme values
    send_item(OP_APPEND, 32'sh7FFF_FFFF, 8'hFF);
    send_item(OP_APPEND, 32'sh8000_0000, 0);
    send_item(OP_APPEND, -1, 0);
    send_item(OP_APPEND, 0, 0);
    // Positions out of range: zero, one past the tail, high bits
    send_item(OP_DEL_POS, 0, 0);
    send_item(OP_DEL_POS, 0, 5);
    send_item(OP_DEL_POS, 0, 8'd128);
    send_item(OP_DEL_POS, 0, 8'd255);
    // Unused opcodes
    send_item(OP_SPARE_LO, -1, 8'hFF);
    send_item(OP_SPARE_HI, -1, 8'hFF);
    send_item(OP_DUMP_FWD, 0, 0);
    send_item(OP_DUMP_REV, 0, 0);
    // Middle, head and tail deletes
    send_item(OP_DEL_POS, 0, 2);
    send_item(OP_DEL_HEAD, 0, 0);
    send_item(OP_DEL_TAIL, 0, 0);

    // Random traffic in trends that fill, drain or mix the list
    for (int ph = 0; ph < 4; ph++) begin
      gap_pct = gap_by_phase[ph];
      stall_pct <= stall_by_phase[ph];
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        if (i % 24 == 0) trend = trend_t'($urandom_range(2));
        roll = $urandom_range(99);
        case (trend)
          TREND_FILL:
            opc = (roll < 80) ? OP_APPEND : (roll < 92) ? any_dump() : any_delete();
          TREND_DRAIN:
            opc = (roll < 15) ? OP_APPEND : (roll < 85) ? any_delete() :
                  (roll < 97) ? any_dump() : any_spare();
          default:
            opc = (roll < 40) ? OP_APPEND : (roll < 70) ? any_delete() :
                  (roll < 95) ? any_dump() : any_spare();
        endcase
        pos = ($urandom_range(3) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(17));
        send_item(opc, $urandom, pos);
      end
    end
    s_tvalid <= 1'b0;

    // Drain the results, then allow stray transfers to show up
    while (outstanding != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (mismatches == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Overall time limit
  initial begin
    #2_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+design
design/olpd_pkg.sv
design/olpd_front.sv
design/olpd_queue.sv
design/olpd_back.sv
design/ordered_list_with_position_delete.sv
sim/olpd_checker.sv
sim/tb.sv
